/* hw/rtl/frd_pkg.sv */
// Package for the vsync frame rate divider: field widths, command and register codes,
// sequencer states and the request and response bundles of the shared divider.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package frd_pkg;

  localparam int unsigned RATE_W       = 10;
  localparam int unsigned TS_W         = 63;
  localparam int unsigned PER_W        = 31;
  localparam int unsigned PROD_W       = PER_W + RATE_W;
  localparam int unsigned APB_ADDR_W   = 4;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned MAX_RATE_DEF = 1023;

  localparam logic CMD_RATE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    REG_PREF = 2'd0,
    REG_MIN  = 2'd1,
    REG_MAX  = 2'd2
  } frd_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MATCH,
    ST_EXACT,
    ST_LOWER,
    ST_UPPER,
    ST_SEARCH,
    ST_SEARCH_DIV,
    ST_FINAL,
    ST_QUOT,
    ST_TICK,
    ST_RESULT
  } frd_state_e;

  typedef enum logic {
    CTX_FIRST,
    CTX_SEARCH
  } frd_ctx_e;

  typedef struct packed {
    logic              start;
    logic [RATE_W-1:0] dividend;
    logic [RATE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] quot;
    logic [RATE_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/frd_div.sv */
// Iterative restoring divider for rate values, one quotient bit per cycle.
// Depends on frd_pkg for the operand width and the request and response bundles.
`default_nettype none

module frd_div (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire frd_pkg::div_req_t req_i,
  output frd_pkg::div_rsp_t     rsp_o
);
  import frd_pkg::*;

  localparam int unsigned CntW = $clog2(RATE_W + 1);

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [RATE_W-1:0] quo_q, quo_d;
  logic [RATE_W-1:0] rem_q, rem_d;
  logic [RATE_W-1:0] den_q, den_d;
  logic [RATE_W:0]   shifted;
  logic [RATE_W:0]   diff;

  always_comb begin
    shifted = {rem_q, quo_q[RATE_W-1]};
    diff    = shifted - {1'b0, den_q};
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    if (req_i.start) begin
      cnt_d = CntW'(RATE_W);
      quo_d = req_i.dividend;
      rem_d = '0;
      den_d = req_i.divisor;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (shifted >= {1'b0, den_q}) begin
        rem_d = diff[RATE_W-1:0];
        quo_d = {quo_q[RATE_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[RATE_W-1:0];
        quo_d = {quo_q[RATE_W-2:0], 1'b0};
      end
      if (cnt_q == CntW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

/* hw/rtl/vsync_frame_rate_divider.sv */
// Top level of the vsync frame rate divider: sequencer, state, configuration registers.
// Depends on frd_pkg and on the shared iterative divider frd_div.
//
// Usage. Items enter on a valid/ready channel; each one is a rate update (cmd 0,
// carrying the vsync rate) or a frame tick (cmd 1, carrying timestamp and vsync
// period). Every accepted item gives exactly one result transfer on the output
// valid/ready channel. The rate registers are written over the APB-style port,
// which never waits, and should only be changed while the block is idle.
// The block works on one item at a time and drops ready while it is busy.
// A frame tick's result passes through registers: the period-by-divisor product is
// registered at the accepting edge, then the result of the saturating add, and the
// output register is loaded last, when the output channel is free.
// A rate update is worked out by the single shared divider, which makes one division
// for the exact test of the preferred rate, one per candidate tried in each direction
// when looking for the nearest divisor, one per k of the range search and one for the
// final divisor. Reset sets the divisor to one, clears the phase and the restart
// flag and zeroes the rate registers. A finished result sits in the output register
// until it is taken; a stalled receiver holds the block in its last state.
`default_nettype none

module vsync_frame_rate_divider #(
  parameter int unsigned MAX_RATE = frd_pkg::MAX_RATE_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            cmd_i,
  input  wire logic [frd_pkg::RATE_W-1:0]      vsync_rate_i,
  input  wire logic [frd_pkg::TS_W-1:0]        timestamp_ns_i,
  input  wire logic [frd_pkg::PER_W-1:0]       vsync_period_ns_i,
  // output channel
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [frd_pkg::RATE_W-1:0]           draw_fps_o,
  output logic [frd_pkg::RATE_W-1:0]           divisor_out_o,
  output logic                                 divisor_changed_o,
  output logic                                 no_skip_o,
  output logic [frd_pkg::TS_W-1:0]             target_timestamp_o,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [frd_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [frd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [frd_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);
  import frd_pkg::*;

  // Rates saturate at MAX_RATE, which is capped at the largest field value.
  localparam int unsigned RateFull = (1 << RATE_W) - 1;
  localparam int unsigned RateCap  = (MAX_RATE > RateFull) ? RateFull : MAX_RATE;

  // Configuration registers.
  logic [RATE_W-1:0] pref_q, min_q, max_q;
  logic [RATE_W-1:0] wdata_sat;
  logic [RATE_W-1:0] vsync_sat;
  logic              cfg_we;
  frd_reg_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = frd_reg_e'(paddr[3:2]);

  always_comb begin
    wdata_sat = (32'(pwdata[RATE_W-1:0]) > RateCap) ? RATE_W'(RateCap) : pwdata[RATE_W-1:0];
    vsync_sat = (32'(vsync_rate_i) > RateCap) ? RATE_W'(RateCap) : vsync_rate_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pref_q <= '0;
      min_q  <= '0;
      max_q  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PREF: pref_q <= wdata_sat;
        REG_MIN:  min_q  <= wdata_sat;
        REG_MAX:  max_q  <= wdata_sat;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PREF: prdata = APB_DATA_W'(pref_q);
      REG_MIN:  prdata = APB_DATA_W'(min_q);
      REG_MAX:  prdata = APB_DATA_W'(max_q);
      default:  prdata = '0;
    endcase
  end

  // Shared divider.
  div_req_t div_req;
  div_rsp_t div_rsp;

  frd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer and working registers.
  frd_state_e        state_q, state_d;
  frd_ctx_e          ctx_q, ctx_d;
  logic [RATE_W-1:0] frame_div_q, frame_div_d;
  logic [RATE_W-1:0] phase_q, phase_d;
  logic              pending_q, pending_d;
  logic [RATE_W-1:0] v_q, v_d;
  logic [RATE_W-1:0] t_q, t_d;
  logic [RATE_W-1:0] d_q, d_d;
  logic [RATE_W-1:0] lo_q, lo_d;
  logic [RATE_W-1:0] k_q, k_d;
  logic [RATE_W-1:0] pick0_q, pick0_d;
  logic [RATE_W-1:0] draw_q, draw_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [TS_W-1:0]   ts_q, ts_d;
  logic [RATE_W-1:0] res_draw_q, res_draw_d;
  logic              res_changed_q, res_changed_d;
  logic              res_skip_q, res_skip_d;
  logic [TS_W-1:0]   res_target_q, res_target_d;

  logic              match_fin;
  logic [RATE_W-1:0] match_res;
  logic              out_load;
  logic [RATE_W-1:0] ph_eff;
  logic [RATE_W:0]   ph_inc;
  logic [TS_W:0]     sum;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    ctx_d         = ctx_q;
    frame_div_d   = frame_div_q;
    phase_d       = phase_q;
    pending_d     = pending_q;
    v_d           = v_q;
    t_d           = t_q;
    d_d           = d_q;
    lo_d          = lo_q;
    k_d           = k_q;
    pick0_d       = pick0_q;
    draw_d        = draw_q;
    prod_d        = prod_q;
    ts_d          = ts_q;
    res_draw_d    = res_draw_q;
    res_changed_d = res_changed_q;
    res_skip_d    = res_skip_q;
    res_target_d  = res_target_q;
    div_req       = '0;
    match_fin     = 1'b0;
    match_res     = '0;
    out_load      = 1'b0;
    // A pending restart clears the phase before the tick is judged.
    ph_eff        = pending_q ? '0 : phase_q;
    ph_inc        = {1'b0, ph_eff} + 1'b1;
    sum           = {1'b0, ts_q} + (TS_W + 1)'(prod_q);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == CMD_TICK) begin
            res_draw_d    = '0;
            res_changed_d = 1'b0;
            res_skip_d    = (ph_eff == '0);
            pending_d     = 1'b0;
            if (frame_div_q != '0 && ph_inc >= {1'b0, frame_div_q}) begin
              phase_d = '0;
            end else begin
              phase_d = ph_inc[RATE_W-1:0];
            end
            prod_d  = PROD_W'(vsync_period_ns_i) * PROD_W'(frame_div_q);
            ts_d    = timestamp_ns_i;
            state_d = ST_TICK;
          end else begin
            res_skip_d   = 1'b0;
            res_target_d = '0;
            v_d          = vsync_sat;
            t_d          = pref_q;
            ctx_d        = CTX_FIRST;
            state_d      = ST_MATCH;
          end
        end
      end

      // Nearest divisor of v to t: t itself when it divides v, else the
      // closer of the neighbouring divisors, the lower one on a tie; v when t is zero or exceeds v.
      ST_MATCH: begin
        if (t_q == '0 || t_q > v_q) begin
          match_fin = 1'b1;
          match_res = v_q;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = v_q;
          div_req.divisor  = t_q;
          state_d          = ST_EXACT;
        end
      end

      ST_EXACT: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            match_fin = 1'b1;
            match_res = t_q;
          end else begin
            d_d              = t_q - 1'b1;
            div_req.start    = 1'b1;
            div_req.dividend = v_q;
            div_req.divisor  = t_q - 1'b1;
            state_d          = ST_LOWER;
          end
        end
      end

      ST_LOWER: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = v_q;
          if (div_rsp.rem == '0) begin
            lo_d            = d_q;
            d_d             = t_q + 1'b1;
            div_req.divisor = t_q + 1'b1;
            state_d         = ST_UPPER;
          end else begin
            d_d             = d_q - 1'b1;
            div_req.divisor = d_q - 1'b1;
          end
        end
      end

      ST_UPPER: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            match_fin = 1'b1;
            match_res = ((d_q - t_q) < (t_q - lo_q)) ? d_q : lo_q;
          end else begin
            d_d              = d_q + 1'b1;
            div_req.start    = 1'b1;
            div_req.dividend = v_q;
            div_req.divisor  = d_q + 1'b1;
          end
        end
      end

      // Range search over v/k for k below v; without a hit the first pick stands.
      ST_SEARCH: begin
        if (k_q < v_q) begin
          div_req.start    = 1'b1;
          div_req.dividend = v_q;
          div_req.divisor  = k_q;
          state_d          = ST_SEARCH_DIV;
        end else begin
          draw_d  = pick0_q;
          state_d = ST_FINAL;
        end
      end

      ST_SEARCH_DIV: begin
        if (div_rsp.done) begin
          if (min_q <= div_rsp.quot && div_rsp.quot <= max_q) begin
            t_d     = div_rsp.quot;
            ctx_d   = CTX_SEARCH;
            state_d = ST_MATCH;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_SEARCH;
          end
        end
      end

      ST_FINAL: begin
        res_draw_d    = draw_q;
        res_changed_d = 1'b0;
        if (draw_q == '0) begin
          state_d = ST_RESULT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = v_q;
          div_req.divisor  = draw_q;
          state_d          = ST_QUOT;
        end
      end

      ST_QUOT: begin
        if (div_rsp.done) begin
          if (div_rsp.quot != frame_div_q) begin
            frame_div_d   = div_rsp.quot;
            pending_d     = 1'b1;
            res_changed_d = 1'b1;
          end
          state_d = ST_RESULT;
        end
      end

      ST_TICK: begin
        res_target_d = sum[TS_W] ? {TS_W{1'b1}} : sum[TS_W-1:0];
        state_d      = ST_RESULT;
      end

      ST_RESULT: begin
        if (!out_valid_o || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A finished nearest-divisor match: the first pick may send us to the
    // range search, a pick from the search is the draw rate.
    if (match_fin) begin
      if (ctx_q == CTX_FIRST) begin
        pick0_d = match_res;
        if (match_res < min_q || match_res > max_q) begin
          if (v_q == '0) begin
            draw_d  = '0;
            state_d = ST_FINAL;
          end else begin
            k_d     = RATE_W'(1);
            state_d = ST_SEARCH;
          end
        end else begin
          draw_d  = match_res;
          state_d = ST_FINAL;
        end
      end else begin
        draw_d  = match_res;
        state_d = ST_FINAL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ctx_q       <= CTX_FIRST;
      frame_div_q <= RATE_W'(1);
      phase_q     <= '0;
      pending_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctx_q       <= ctx_d;
      frame_div_q <= frame_div_d;
      phase_q     <= phase_d;
      pending_q   <= pending_d;
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q           <= v_d;
    t_q           <= t_d;
    d_q           <= d_d;
    lo_q          <= lo_d;
    k_q           <= k_d;
    pick0_q       <= pick0_d;
    draw_q        <= draw_d;
    prod_q        <= prod_d;
    ts_q          <= ts_d;
    res_draw_q    <= res_draw_d;
    res_changed_q <= res_changed_d;
    res_skip_q    <= res_skip_d;
    res_target_q  <= res_target_d;
    if (out_load) begin
      draw_fps_o         <= res_draw_q;
      divisor_out_o      <= frame_div_q;
      divisor_changed_o  <= res_changed_q;
      no_skip_o          <= res_skip_q;
      target_timestamp_o <= res_target_q;
    end
  end

endmodule

`default_nettype wire
